/* design/dmgr_pkg.sv */
`timescale 1ns / 1ps

package dmgr_pkg;

  // coordinate and field widths
  localparam int CoordW = 13;
  localparam int FontW  = 7;
  localparam int ColsW  = 11;
  localparam int IdxW   = 10;
  localparam int OriW   = 2;

  // merge window in undamaged cells
  localparam int MergeGap = 3;
  localparam int GapW     = $clog2(MergeGap + 1);

  // configuration port
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 13;

  localparam logic [CfgAddrW-1:0] RegOrientation  = 3'd0;
  localparam logic [CfgAddrW-1:0] RegFontWidth    = 3'd1;
  localparam logic [CfgAddrW-1:0] RegFontHeight   = 3'd2;
  localparam logic [CfgAddrW-1:0] RegColumns      = 3'd3;
  localparam logic [CfgAddrW-1:0] RegScreenWidth  = 3'd4;
  localparam logic [CfgAddrW-1:0] RegScreenHeight = 3'd5;

  // display orientation codes
  localparam logic [OriW-1:0] OriNormal = 2'd0;
  localparam logic [OriW-1:0] OriFlip   = 2'd1;
  localparam logic [OriW-1:0] OriRight  = 2'd2;
  localparam logic [OriW-1:0] OriLeft   = 2'd3;

  typedef struct packed {
    logic [OriW-1:0]   orientation;
    logic [FontW-1:0]  glyph_w;
    logic [FontW-1:0]  glyph_h;
    logic [ColsW-1:0]  columns;
    logic [CoordW-1:0] screen_width;
    logic [CoordW-1:0] screen_height;
  } cfg_t;

  // column and row products, wrapped to coordinate width
  typedef struct packed {
    logic [CoordW-1:0] cw;
    logic [CoordW-1:0] cw1;
    logic [CoordW-1:0] rh;
    logic [CoordW-1:0] rh1;
  } prod_t;

  typedef struct packed {
    logic [CoordW-1:0] x1;
    logic [CoordW-1:0] y1;
    logic [CoordW-1:0] x2;
    logic [CoordW-1:0] y2;
  } rect_t;

endpackage

/* design/damage_rectangle_merger_core.sv */
`timescale 1ns / 1ps

// path: closing word via input and product registers, rectangle into the output register
// throughput: one cell word per cycle; only a stalled, occupied output register holds it up
// pipeline: input register, product register (four small multiplies), merge into output register
// reset: gap counter, valid flags and open rectangle cleared; registers take their defaults
// (orientation normal, font 8x16, 128 columns, screen 1024x768)
module damage_rectangle_merger_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // cell words
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          damaged_i,
  input  logic [dmgr_pkg::IdxW-1:0]     col_i,
  input  logic [dmgr_pkg::IdxW-1:0]     row_i,
  // rectangle words
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [dmgr_pkg::CoordW-1:0]   rect_x1_o,
  output logic [dmgr_pkg::CoordW-1:0]   rect_y1_o,
  output logic [dmgr_pkg::CoordW-1:0]   rect_x2_o,
  output logic [dmgr_pkg::CoordW-1:0]   rect_y2_o,
  // register writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dmgr_pkg::CfgAddrW-1:0] cfg_index_i,
  input  logic [dmgr_pkg::CfgDataW-1:0] cfg_data_i
);
  import dmgr_pkg::*;

  cfg_t cfg_q;

  logic            a_valid_q;
  logic            a_damaged_q;
  logic [IdxW-1:0] a_col_q;
  logic [IdxW-1:0] a_row_q;

  logic            p_valid_q;
  logic            p_damaged_q;
  logic            p_row_end_q;
  prod_t           p_prod_q;

  logic [GapW-1:0]   gap_q, gap_d;
  rect_t             open_q, open_d;
  logic              out_valid_q;
  rect_t             out_q;

  logic        out_free;
  logic        emit;
  logic        p_move, p_ready;
  logic        a_move, a_ready;
  logic        in_acc;
  rect_t       cell_rect;
  prod_t       prod_d;
  logic        row_end_d;
  logic [CoordW-1:0] cw_full, rh_full;
  logic [CoordW-1:0] cw1_full, rh1_full;

  // register file, writes always taken
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.orientation   <= OriNormal;
      cfg_q.glyph_w       <= FontW'(8);
      cfg_q.glyph_h       <= FontW'(16);
      cfg_q.columns       <= ColsW'(128);
      cfg_q.screen_width  <= CoordW'(1024);
      cfg_q.screen_height <= CoordW'(768);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegOrientation:  cfg_q.orientation   <= cfg_data_i[OriW-1:0];
        RegFontWidth:    cfg_q.glyph_w       <= cfg_data_i[FontW-1:0];
        RegFontHeight:   cfg_q.glyph_h       <= cfg_data_i[FontW-1:0];
        RegColumns:      cfg_q.columns       <= cfg_data_i[ColsW-1:0];
        RegScreenWidth:  cfg_q.screen_width  <= cfg_data_i[CoordW-1:0];
        RegScreenHeight: cfg_q.screen_height <= cfg_data_i[CoordW-1:0];
        default: ;
      endcase
    end
  end

  // flow control, only the output register can block
  assign out_free   = !out_valid_q || !out_stall_i;
  assign p_move     = p_valid_q && (!emit || out_free);
  assign p_ready    = !p_valid_q || p_move;
  assign a_move     = a_valid_q && p_ready;
  assign a_ready    = !a_valid_q || a_move;
  assign in_stall_o = !a_ready;
  assign in_acc     = in_valid_i && a_ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_acc) begin
      a_valid_q <= 1'b1;
    end else if (a_move) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_damaged_q <= damaged_i;
      a_col_q     <= col_i;
      a_row_q     <= row_i;
    end
  end

  // column and row products, row end test
  assign cw_full   = CoordW'(a_col_q) * CoordW'(cfg_q.glyph_w);
  assign rh_full   = CoordW'(a_row_q) * CoordW'(cfg_q.glyph_h);
  assign cw1_full  = (CoordW'(a_col_q) + CoordW'(1)) * CoordW'(cfg_q.glyph_w);
  assign rh1_full  = (CoordW'(a_row_q) + CoordW'(1)) * CoordW'(cfg_q.glyph_h);
  assign prod_d.cw  = cw_full;
  assign prod_d.rh  = rh_full;
  assign prod_d.cw1 = cw1_full;
  assign prod_d.rh1 = rh1_full;
  assign row_end_d  = (ColsW'(a_col_q) + ColsW'(1)) >= cfg_q.columns;

  // product register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (a_move) begin
      p_valid_q <= 1'b1;
    end else if (p_move) begin
      p_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_move) begin
      p_damaged_q <= a_damaged_q;
      p_row_end_q <= row_end_d;
      p_prod_q    <= prod_d;
    end
  end

  // screen rectangle of the cell
  dmgr_geom u_geom (
    .cfg_i  (cfg_q),
    .prod_i (p_prod_q),
    .cell_o (cell_rect)
  );

  // merge into the open rectangle, gap countdown, row end flush
  always_comb begin
    gap_d  = gap_q;
    open_d = open_q;
    emit   = 1'b0;
    if (p_damaged_q) begin
      if (gap_q != '0) begin
        open_d.x1 = (cell_rect.x1 < open_q.x1) ? cell_rect.x1 : open_q.x1;
        open_d.y1 = (cell_rect.y1 < open_q.y1) ? cell_rect.y1 : open_q.y1;
        open_d.x2 = (cell_rect.x2 > open_q.x2) ? cell_rect.x2 : open_q.x2;
        open_d.y2 = (cell_rect.y2 > open_q.y2) ? cell_rect.y2 : open_q.y2;
      end else begin
        open_d = cell_rect;
      end
      gap_d = GapW'(MergeGap);
    end else if (gap_q != '0) begin
      gap_d = gap_q - GapW'(1);
      emit  = (gap_q == GapW'(1));
    end
    if (p_row_end_q && gap_d != '0) begin
      gap_d = '0;
      emit  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q  <= '0;
      open_q <= '0;
    end else if (p_move) begin
      gap_q  <= gap_d;
      open_q <= open_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (p_move && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_free) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_move && emit) begin
      out_q <= open_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign rect_x1_o   = out_q.x1;
  assign rect_y1_o   = out_q.y1;
  assign rect_x2_o   = out_q.x2;
  assign rect_y2_o   = out_q.y2;

  // gap counter stays within the merge window
  a_gap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gap_q <= GapW'(MergeGap))
    else $error("gap counter beyond merge window");

  // a row end leaves no rectangle open
  a_row_end_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p_move && p_row_end_q) |=> (gap_q == '0))
    else $error("rectangle still open after row end");

  // a rectangle is only emitted from an open one or a damaged cell
  a_emit_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p_move && emit) |-> (gap_q != '0 || p_damaged_q))
    else $error("rectangle emitted with nothing open");

  // empty input register never stalls the cell side
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !a_valid_q |-> !in_stall_o)
    else $error("stall raised with empty input register");

  // a blocked product stage keeps its word
  a_p_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p_valid_q && !p_move) |=> p_valid_q)
    else $error("product stage word lost");

endmodule

/* design/dmgr_geom.sv */
`timescale 1ns / 1ps

module dmgr_geom (
  input  dmgr_pkg::cfg_t  cfg_i,
  input  dmgr_pkg::prod_t prod_i,
  output dmgr_pkg::rect_t cell_o
);
  import dmgr_pkg::*;

  logic              rotated;
  logic [FontW-1:0]  ext_w;
  logic [FontW-1:0]  ext_h;
  logic [CoordW-1:0] x1;
  logic [CoordW-1:0] y1;

  // cell extent swaps when the display is turned sideways
  assign rotated = cfg_i.orientation[1];
  assign ext_w   = rotated ? cfg_i.glyph_h : cfg_i.glyph_w;
  assign ext_h   = rotated ? cfg_i.glyph_w : cfg_i.glyph_h;

  // top-left corner per orientation, all wrapping
  always_comb begin
    case (cfg_i.orientation)
      OriNormal: begin
        x1 = prod_i.cw;
        y1 = prod_i.rh;
      end
      OriFlip: begin
        x1 = cfg_i.screen_width - prod_i.cw1;
        y1 = cfg_i.screen_height - prod_i.rh1;
      end
      OriRight: begin
        x1 = cfg_i.screen_width - prod_i.rh1;
        y1 = prod_i.cw;
      end
      default: begin
        x1 = prod_i.rh;
        y1 = cfg_i.screen_height - prod_i.cw1;
      end
    endcase
  end

  // exclusive bottom-right corner
  assign cell_o.x1 = x1;
  assign cell_o.y1 = y1;
  assign cell_o.x2 = x1 + CoordW'(ext_w);
  assign cell_o.y2 = y1 + CoordW'(ext_h);

endmodule
